// ===== hw/rtl/lds_pkg.sv =====
// Shared types and constants for the Lambert diffuse shader.
// Used by every module of the shader; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package lds_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int COS_FRAC_DEF    = 16;

    localparam int COL_W = 9;
    localparam int PIX_W = 8;
    localparam int IDX_W = 2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam logic [IDX_W-1:0] REG_LIGHT_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_LIGHT_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_LIGHT_Z = 2'd2;

    typedef struct packed {
        logic [COL_W-1:0] amb_r;
        logic [COL_W-1:0] amb_g;
        logic [COL_W-1:0] amb_b;
        logic [COL_W-1:0] dif_r;
        logic [COL_W-1:0] dif_g;
        logic [COL_W-1:0] dif_b;
    } t_col;

endpackage
`default_nettype wire

// ===== hw/rtl/lds_vec.sv =====
// Vector front end: normal and light vectors, squared lengths and dot product.
// Four register stages; depends on lds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lds_vec #(
    parameter int W = lds_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic [3:0]           i_en,
    input  wire logic [W-1:0]         i_hit   [3],
    input  wire logic [W-1:0]         i_ctr   [3],
    input  wire logic [W-1:0]         i_light [3],
    input  wire lds_pkg::t_col        i_col,
    output logic [2*W+3:0]            o_dot,
    output logic [2*W+3:0]            o_nn,
    output logic [2*W+3:0]            o_ll,
    output logic                      o_zero,
    output lds_pkg::t_col             o_col
);
    localparam int DW = W + 1;
    localparam int SQ = 2 * DW;
    localparam int NW = SQ + 2;

    logic [DW-1:0] r_n [3];
    logic [DW-1:0] r_l [3];
    logic [SQ-1:0] r_nn2 [3];
    logic [SQ-1:0] r_ll2 [3];
    logic [SQ-1:0] r_nl [3];
    logic [2:0]    r_neg_f;
    logic [NW-1:0] r_nn3, r_ll3, r_pos3, r_neg3;
    lds_pkg::t_col r_col1, r_col2, r_col3, r_col4;

    logic [DW-1:0] w_an [3];
    logic [DW-1:0] w_al [3];
    logic [NW-1:0] w_nn, w_ll, w_pos, w_neg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_an[i] = r_n[i][DW-1] ? (~r_n[i]) + DW'(1) : r_n[i];
            w_al[i] = r_l[i][DW-1] ? (~r_l[i]) + DW'(1) : r_l[i];
        end
        w_nn  = '0;
        w_ll  = '0;
        w_pos = '0;
        w_neg = '0;
        for (int i = 0; i < 3; i++) begin
            w_nn = w_nn + {2'b00, r_nn2[i]};
            w_ll = w_ll + {2'b00, r_ll2[i]};
            if (r_neg_f[i]) begin
                w_neg = w_neg + {2'b00, r_nl[i]};
            end else begin
                w_pos = w_pos + {2'b00, r_nl[i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= {i_hit[i][W-1], i_hit[i]} - {i_ctr[i][W-1], i_ctr[i]};
                r_l[i] <= {i_light[i][W-1], i_light[i]} - {i_hit[i][W-1], i_hit[i]};
            end
            r_col1 <= i_col;
        end
        if (i_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_nn2[i]   <= {{DW{1'b0}}, w_an[i]} * {{DW{1'b0}}, w_an[i]};
                r_ll2[i]   <= {{DW{1'b0}}, w_al[i]} * {{DW{1'b0}}, w_al[i]};
                r_nl[i]    <= {{DW{1'b0}}, w_an[i]} * {{DW{1'b0}}, w_al[i]};
                r_neg_f[i] <= r_n[i][DW-1] ^ r_l[i][DW-1];
            end
            r_col2 <= r_col1;
        end
        if (i_en[2]) begin
            r_nn3  <= w_nn;
            r_ll3  <= w_ll;
            r_pos3 <= w_pos;
            r_neg3 <= w_neg;
            r_col3 <= r_col2;
        end
        if (i_en[3]) begin
            o_zero <= (r_nn3 == '0) || (r_ll3 == '0) || (r_pos3 <= r_neg3);
            o_dot  <= r_pos3 - r_neg3;
            o_nn   <= r_nn3;
            o_ll   <= r_ll3;
            r_col4 <= r_col3;
        end
    end

    assign o_col = r_col4;

endmodule
`default_nettype wire

// ===== hw/rtl/lds_mul.sv =====
// Two wide products, |n|^2*|l|^2 and dot^2, split into half-width partials.
// Two register stages; depends on lds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lds_mul #(
    parameter int NW = 2 * lds_pkg::COORD_WIDTH_DEF + 4
) (
    input  wire logic              i_clk,
    input  wire logic [1:0]        i_en,
    input  wire logic [NW-1:0]     i_nn,
    input  wire logic [NW-1:0]     i_ll,
    input  wire logic [NW-1:0]     i_dot,
    input  wire logic              i_zero,
    input  wire lds_pkg::t_col     i_col,
    output logic [2*NW-1:0]        o_p,
    output logic [2*NW-1:0]        o_q,
    output logic                   o_zero,
    output lds_pkg::t_col          o_col
);
    localparam int H  = (NW + 1) / 2;
    localparam int PW = 2 * NW;

    logic [2*H-1:0] w_a [2];
    logic [2*H-1:0] w_b [2];
    logic [2*H-1:0] r_pp [2][4];
    logic [4*H-1:0] w_sum [2];
    logic           r_zero1;
    lds_pkg::t_col  r_col1;

    always_comb begin
        w_a[0] = {{(2*H-NW){1'b0}}, i_nn};
        w_b[0] = {{(2*H-NW){1'b0}}, i_ll};
        w_a[1] = {{(2*H-NW){1'b0}}, i_dot};
        w_b[1] = {{(2*H-NW){1'b0}}, i_dot};
        for (int m = 0; m < 2; m++) begin
            w_sum[m] = {{(2*H){1'b0}}, r_pp[m][0]}
                     + (({{(2*H){1'b0}}, r_pp[m][1]} + {{(2*H){1'b0}}, r_pp[m][2]}) << H)
                     + {r_pp[m][3], {(2*H){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int m = 0; m < 2; m++) begin
                r_pp[m][0] <= {{H{1'b0}}, w_a[m][H-1:0]}   * {{H{1'b0}}, w_b[m][H-1:0]};
                r_pp[m][1] <= {{H{1'b0}}, w_a[m][H-1:0]}   * {{H{1'b0}}, w_b[m][2*H-1:H]};
                r_pp[m][2] <= {{H{1'b0}}, w_a[m][2*H-1:H]} * {{H{1'b0}}, w_b[m][H-1:0]};
                r_pp[m][3] <= {{H{1'b0}}, w_a[m][2*H-1:H]} * {{H{1'b0}}, w_b[m][2*H-1:H]};
            end
            r_zero1 <= i_zero;
            r_col1  <= i_col;
        end
        if (i_en[1]) begin
            o_p    <= w_sum[0][PW-1:0];
            o_q    <= w_sum[1][PW-1:0];
            o_zero <= r_zero1;
            o_col  <= r_col1;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lds_cstep.sv =====
// One bit of the cosine: largest c with c^2*P <= dot^2*2^(2F), decided at bit K.
// Keeps remainder R and running product c*P; depends on lds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lds_cstep #(
    parameter int XW = 140,
    parameter int PW = 104,
    parameter int CW = 17,
    parameter int K  = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [XW-1:0]     i_r,
    input  wire logic [XW-1:0]     i_t,
    input  wire logic [CW-1:0]     i_c,
    input  wire logic [PW-1:0]     i_p,
    input  wire logic              i_zero,
    input  wire lds_pkg::t_col     i_col,
    output logic [XW-1:0]          o_r,
    output logic [XW-1:0]          o_t,
    output logic [CW-1:0]          o_c,
    output logic [PW-1:0]          o_p,
    output logic                   o_zero,
    output lds_pkg::t_col          o_col
);
    logic [XW-1:0] w_pext;
    logic [XW-1:0] w_trial;
    logic          w_take;

    assign w_pext  = {{(XW-PW){1'b0}}, i_p};
    assign w_trial = (i_t << (K + 1)) + (w_pext << (2 * K));
    assign w_take  = (w_trial <= i_r);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_r    <= w_take ? i_r - w_trial : i_r;
            o_t    <= w_take ? i_t + (w_pext << K) : i_t;
            o_c    <= w_take ? i_c | (CW'(1) << K) : i_c;
            o_p    <= i_p;
            o_zero <= i_zero;
            o_col  <= i_col;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lds_shade.sv =====
// Colour stage: ambient + diffuse*cosine per channel, clamped to 0..255.
// One register stage; depends on lds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lds_shade #(
    parameter int F = lds_pkg::COS_FRAC_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [F:0]                 i_c,
    input  wire logic                       i_zero,
    input  wire lds_pkg::t_col              i_col,
    output logic [lds_pkg::PIX_W-1:0]       o_red,
    output logic [lds_pkg::PIX_W-1:0]       o_green,
    output logic [lds_pkg::PIX_W-1:0]       o_blue
);
    localparam int CW = F + 1;
    localparam int AW = lds_pkg::COL_W;

    logic [CW-1:0] w_cos;

    function automatic logic [lds_pkg::PIX_W-1:0] chan(
        input logic [AW-1:0] amb,
        input logic [AW-1:0] dif,
        input logic [CW-1:0] c
    );
        logic [AW+CW-1:0] pr;
        logic [AW:0]      v;
        pr = {{CW{1'b0}}, dif} * {{AW{1'b0}}, c};
        v  = {1'b0, amb} + {1'b0, pr[F +: AW]};
        chan = (v > {2'b00, lds_pkg::PIX_MAX}) ? lds_pkg::PIX_MAX : v[lds_pkg::PIX_W-1:0];
    endfunction

    assign w_cos = i_zero ? '0 : i_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_red   <= chan(i_col.amb_r, i_col.dif_r, w_cos);
            o_green <= chan(i_col.amb_g, i_col.dif_g, w_cos);
            o_blue  <= chan(i_col.amb_b, i_col.dif_b, w_cos);
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lambert_diffuse_shader.sv =====
// Throughput: one transaction per cycle while o_stall is low; one register stage per cosine bit sets the depth.
// Stalls hold each stage only while the stage after it is full and held.
// Reset (synchronous, active low) clears all valid bits and the light registers.
// Depends on lds_pkg, lds_vec, lds_mul, lds_cstep and lds_shade.
`timescale 1ns / 1ps
`default_nettype none
module lambert_diffuse_shader #(
    parameter int COORD_WIDTH   = lds_pkg::COORD_WIDTH_DEF,
    parameter int COS_FRAC_BITS = lds_pkg::COS_FRAC_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lds_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [COORD_WIDTH-1:0]        i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [COORD_WIDTH-1:0]        i_hit_x,
    input  wire logic [COORD_WIDTH-1:0]        i_hit_y,
    input  wire logic [COORD_WIDTH-1:0]        i_hit_z,
    input  wire logic [COORD_WIDTH-1:0]        i_centre_x,
    input  wire logic [COORD_WIDTH-1:0]        i_centre_y,
    input  wire logic [COORD_WIDTH-1:0]        i_centre_z,
    input  wire logic [lds_pkg::COL_W-1:0]     i_ambient_red,
    input  wire logic [lds_pkg::COL_W-1:0]     i_ambient_green,
    input  wire logic [lds_pkg::COL_W-1:0]     i_ambient_blue,
    input  wire logic [lds_pkg::COL_W-1:0]     i_diffuse_red,
    input  wire logic [lds_pkg::COL_W-1:0]     i_diffuse_green,
    input  wire logic [lds_pkg::COL_W-1:0]     i_diffuse_blue,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [lds_pkg::PIX_W-1:0]          o_pixel_red,
    output logic [lds_pkg::PIX_W-1:0]          o_pixel_green,
    output logic [lds_pkg::PIX_W-1:0]          o_pixel_blue
);
    localparam int W  = COORD_WIDTH;
    localparam int F  = COS_FRAC_BITS;
    localparam int NW = 2 * W + 4;
    localparam int PW = 2 * NW;
    localparam int XW = PW + 2 * F + 3;
    localparam int CW = F + 1;
    localparam int NS = F + 8;
    localparam int CS = 6;

    logic [W-1:0]   r_light [3];
    logic [NS-1:0]  r_vld;
    logic [NS-1:0]  w_en;

    logic [W-1:0]   w_hit [3];
    logic [W-1:0]   w_ctr [3];
    lds_pkg::t_col  w_col_in;

    logic [NW-1:0]  w_dot, w_nn, w_ll;
    logic           w_zero4;
    lds_pkg::t_col  w_col4;

    logic [PW-1:0]  w_p6, w_q6;
    logic           w_zero6;
    lds_pkg::t_col  w_col6;

    logic [XW-1:0]  w_r    [F+2];
    logic [XW-1:0]  w_t    [F+2];
    logic [CW-1:0]  w_c    [F+2];
    logic [PW-1:0]  w_p    [F+2];
    logic           w_zero [F+2];
    lds_pkg::t_col  w_col  [F+2];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_light[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lds_pkg::REG_LIGHT_X: r_light[0] <= i_cfg_wdata;
                lds_pkg::REG_LIGHT_Y: r_light[1] <= i_cfg_wdata;
                lds_pkg::REG_LIGHT_Z: r_light[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int s = NS - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NS-1];

    assign w_hit[0] = i_hit_x;
    assign w_hit[1] = i_hit_y;
    assign w_hit[2] = i_hit_z;
    assign w_ctr[0] = i_centre_x;
    assign w_ctr[1] = i_centre_y;
    assign w_ctr[2] = i_centre_z;

    assign w_col_in.amb_r = i_ambient_red;
    assign w_col_in.amb_g = i_ambient_green;
    assign w_col_in.amb_b = i_ambient_blue;
    assign w_col_in.dif_r = i_diffuse_red;
    assign w_col_in.dif_g = i_diffuse_green;
    assign w_col_in.dif_b = i_diffuse_blue;

    lds_vec #(.W(W)) u_vec (
        .i_clk   (i_clk),
        .i_en    (w_en[3:0]),
        .i_hit   (w_hit),
        .i_ctr   (w_ctr),
        .i_light (r_light),
        .i_col   (w_col_in),
        .o_dot   (w_dot),
        .o_nn    (w_nn),
        .o_ll    (w_ll),
        .o_zero  (w_zero4),
        .o_col   (w_col4)
    );

    lds_mul #(.NW(NW)) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_en[5:4]),
        .i_nn   (w_nn),
        .i_ll   (w_ll),
        .i_dot  (w_dot),
        .i_zero (w_zero4),
        .i_col  (w_col4),
        .o_p    (w_p6),
        .o_q    (w_q6),
        .o_zero (w_zero6),
        .o_col  (w_col6)
    );

    assign w_r[0]    = {{(XW-PW){1'b0}}, w_q6} << (2 * F);
    assign w_t[0]    = '0;
    assign w_c[0]    = '0;
    assign w_p[0]    = w_p6;
    assign w_zero[0] = w_zero6;
    assign w_col[0]  = w_col6;

    for (genvar j = 0; j <= F; j++) begin : g_cos
        lds_cstep #(.XW(XW), .PW(PW), .CW(CW), .K(F - j)) u_step (
            .i_clk  (i_clk),
            .i_en   (w_en[CS+j]),
            .i_r    (w_r[j]),
            .i_t    (w_t[j]),
            .i_c    (w_c[j]),
            .i_p    (w_p[j]),
            .i_zero (w_zero[j]),
            .i_col  (w_col[j]),
            .o_r    (w_r[j+1]),
            .o_t    (w_t[j+1]),
            .o_c    (w_c[j+1]),
            .o_p    (w_p[j+1]),
            .o_zero (w_zero[j+1]),
            .o_col  (w_col[j+1])
        );
    end

    lds_shade #(.F(F)) u_shade (
        .i_clk   (i_clk),
        .i_en    (w_en[NS-1]),
        .i_c     (w_c[F+1]),
        .i_zero  (w_zero[F+1]),
        .i_col   (w_col[F+1]),
        .o_red   (o_pixel_red),
        .o_green (o_pixel_green),
        .o_blue  (o_pixel_blue)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/lds_chk.sv =====
// Port-level checker for the shader, bound to lambert_diffuse_shader.
// Depends on lds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lds_chk (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_stall,
    input wire logic                      o_valid,
    input wire logic                      i_stall,
    input wire logic [lds_pkg::PIX_W-1:0] o_pixel_red,
    input wire logic [lds_pkg::PIX_W-1:0] o_pixel_green,
    input wire logic [lds_pkg::PIX_W-1:0] o_pixel_blue
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_red)
            && $stable(o_pixel_green) && $stable(o_pixel_blue)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_stall && o_valid) |-> !o_stall)
        else $error("input stalled while output drains");

endmodule

bind lambert_diffuse_shader lds_chk u_lds_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_pixel_red   (o_pixel_red),
    .o_pixel_green (o_pixel_green),
    .o_pixel_blue  (o_pixel_blue)
);
`default_nettype wire
